/* rtl/idbs_pkg.sv */
// Package: shared constants, types and the twiddle functions for the band-pass block.
`default_nettype none
package idbs_pkg;

    localparam int DftPointsDefault   = 64;
    localparam int SampleWidthDefault = 16;
    localparam int ResultsMax         = 64;
    localparam int GuardBits          = 4;
    localparam int TwidFrac           = 16;
    localparam int TwidWidth          = 18;
    localparam int CfgWidth           = 7;
    localparam int CfgIdxWidth        = 2;

    localparam logic [CfgIdxWidth-1:0] REG_SERIES_LENGTH = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_LOW_BIN       = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_HIGH_BIN      = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FWD,
        ST_FWD_WB,
        ST_INV,
        ST_INV_OUT
    } idbs_state_t;

    typedef struct packed {
        logic store_sample;
        logic fwd_clear;
        logic fwd_mac;
        logic fwd_write;
        logic inv_clear;
        logic inv_mac;
        logic inv_emit;
    } idbs_cmd_t;

    // Quotient of two non-negative values by shift and subtract.
    function automatic longint div_pos(input longint num, input longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int i = 62; i >= 0; i--)
        begin
            rem = (rem <<< 1) | ((num >>> i) & 64'sd1);
            quo = quo <<< 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'sd1;
            end
        end
        div_pos = quo;
    endfunction

    // Quarter-wave cosine/sine in Q30 from a truncated Taylor series.
    function automatic void quarter_trig(input longint x, output longint c, output longint s);
        longint x2;
        longint tc;
        longint ts;
        longint k;
        x2 = (x * x) >>> 30;
        tc = 64'sd1 <<< 30;
        c  = tc;
        ts = x;
        s  = x;
        for (k = 1; k <= 8; k++) begin
            tc = div_pos((tc * x2) >>> 30, (2 * k - 1) * (2 * k));
            ts = div_pos((ts * x2) >>> 30, (2 * k) * (2 * k + 1));
            if (k[0]) begin
                c = c - tc;
                s = s - ts;
            end
            else begin
                c = c + tc;
                s = s + ts;
            end
        end
    endfunction

    function automatic longint floor_shift(input longint v, input int sh);
        floor_shift = v >>> sh;
    endfunction

    // Twiddle for index m of an n_pts point transform; sel_sin picks sine.
    function automatic logic signed [TwidWidth-1:0] twiddle(input int m, input int n_pts,
                                                             input logic sel_sin);
        longint c;
        longint s;
        longint cq;
        longint sq;
        int lg;
        int quarter;
        int q;
        int r;
        lg = $clog2(n_pts);
        quarter = n_pts >>> 2;
        q = m >>> (lg - 2);
        r = m & (quarter - 1);
        quarter_trig((64'sd6746518852 * longint'(r)) >>> lg, c, s);
        c = floor_shift(c + (64'sd1 <<< 13), 14);
        s = floor_shift(s + (64'sd1 <<< 13), 14);
        case (q & 3)
            0: begin cq = c;  sq = s;  end
            1: begin cq = -s; sq = c;  end
            2: begin cq = -c; sq = -s; end
            default: begin cq = s; sq = -c; end
        endcase
        twiddle = sel_sin ? TwidWidth'(sq) : TwidWidth'(cq);
    endfunction

endpackage
`default_nettype wire

/* rtl/idbs_ctrl.sv */
// Controller: sequences load, forward DFT, band write-back, inverse DFT and output.
`default_nettype none
module idbs_ctrl
    import idbs_pkg::*;
#(
    parameter int DFT_POINTS = DftPointsDefault
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          out_busy,
    input  wire logic [$clog2(DFT_POINTS):0]   len,
    output logic                               in_ready,
    output logic                               out_valid,
    output logic                               last,
    output idbs_cmd_t                          cmd,
    output logic [$clog2(DFT_POINTS)-1:0]      row,
    output logic [$clog2(DFT_POINTS)-1:0]      col
);
    localparam int LogN = $clog2(DFT_POINTS);
    // Columns past the last point drain the fetch and multiply stages of the pipeline.
    localparam logic [LogN:0] ColLast = (LogN+1)'(DFT_POINTS + 1);

    idbs_state_t state_reg, state_next;
    logic [LogN:0] load_reg, load_next;
    logic [LogN:0] row_reg, row_next;
    logic [LogN:0] col_reg, col_next;

    logic accept;
    logic full;
    logic col_end;
    logic row_fwd_end;
    logic row_inv_end;

    assign in_ready    = (state_reg == ST_LOAD);
    assign accept      = in_valid && in_ready;
    assign full        = (load_reg >= len);
    assign col_end     = (col_reg == ColLast);
    assign row_fwd_end = (row_reg == (LogN+1)'(DFT_POINTS - 1));
    assign row_inv_end = (row_reg == len - 1'b1);
    assign row         = row_reg[LogN-1:0];
    assign col         = col_reg[LogN-1:0];
    assign out_valid   = (state_reg == ST_INV_OUT);
    assign last        = row_inv_end;

    always_comb
    begin
        state_next = state_reg;
        load_next  = load_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (!full)
                    begin
                        load_next = load_reg + 1'b1;
                    end
                    if (full || (load_reg + 1'b1 >= len))
                    begin
                        state_next = ST_FWD;
                        row_next   = '0;
                        col_next   = '0;
                    end
                end
            end
            ST_FWD:
            begin
                col_next = col_reg + 1'b1;
                if (col_end)
                begin
                    state_next = ST_FWD_WB;
                end
            end
            ST_FWD_WB:
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
                if (row_fwd_end)
                begin
                    state_next = ST_INV;
                    row_next   = '0;
                end
                else
                begin
                    state_next = ST_FWD;
                end
            end
            ST_INV:
            begin
                col_next = col_reg + 1'b1;
                if (col_end)
                begin
                    state_next = ST_INV_OUT;
                end
            end
            ST_INV_OUT:
            begin
                if (!out_busy)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                    if (row_inv_end)
                    begin
                        state_next = ST_LOAD;
                        load_next  = '0;
                    end
                    else
                    begin
                        state_next = ST_INV;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_LOAD:    cmd.store_sample = accept && !full;
            ST_FWD:
            begin
                cmd.fwd_clear = (col_reg == '0);
                cmd.fwd_mac   = !col_reg[LogN];
            end
            ST_FWD_WB:  cmd.fwd_write = 1'b1;
            ST_INV:
            begin
                cmd.inv_clear = (col_reg == '0);
                cmd.inv_mac   = !col_reg[LogN];
            end
            ST_INV_OUT: cmd.inv_emit = !out_busy;
            default:    cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            load_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            load_reg  <= load_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/idbs_datapath.sv */
// Datapath: sample store, spectrum store, twiddle lookup and multiply-accumulate.
`default_nettype none
module idbs_datapath
    import idbs_pkg::*;
#(
    parameter int DFT_POINTS   = DftPointsDefault,
    parameter int SAMPLE_WIDTH = SampleWidthDefault
) (
    input  wire logic                              clk,
    input  wire idbs_cmd_t                         cmd,
    input  wire logic [$clog2(DFT_POINTS)-1:0]     row,
    input  wire logic [$clog2(DFT_POINTS)-1:0]     col,
    input  wire logic [$clog2(DFT_POINTS)-1:0]     load_idx,
    input  wire logic [$clog2(DFT_POINTS):0]       len,
    input  wire logic [5:0]                        low_bin,
    input  wire logic [4:0]                        high_bin,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_in,
    output logic signed [SAMPLE_WIDTH-1:0]         filtered_out
);
    localparam int LogN     = $clog2(DFT_POINTS);
    localparam int SpecW    = SAMPLE_WIDTH + GuardBits + 2;
    localparam int ProdW    = SpecW + TwidWidth;
    localparam int AccW     = ProdW + LogN + 2;
    localparam int FwdShift = TwidFrac + LogN - GuardBits;
    localparam int InvShift = TwidFrac + GuardBits;

    logic signed [SAMPLE_WIDTH-1:0] samp_mem [DFT_POINTS];
    logic signed [SpecW-1:0]        re_mem   [DFT_POINTS];
    logic signed [SpecW-1:0]        im_mem   [DFT_POINTS];

    logic [LogN-1:0]               tw_idx;
    logic signed [TwidWidth-1:0]   cos_tab [DFT_POINTS];
    logic signed [TwidWidth-1:0]   sin_tab [DFT_POINTS];
    logic signed [TwidWidth-1:0]   cos_reg;
    logic signed [TwidWidth-1:0]   sin_reg;
    logic signed [SAMPLE_WIDTH-1:0] samp_rd_reg;
    logic signed [SpecW-1:0]       re_rd_reg;
    logic signed [SpecW-1:0]       im_rd_reg;
    logic                          fwd_v_reg, inv_v_reg, clr_reg, live_reg;
    logic signed [ProdW-1:0]       pa_reg, pb_reg;
    logic                          fwd_v2_reg, inv_v2_reg, clr2_reg;
    logic signed [AccW-1:0]        acc_a_reg, acc_b_reg;
    logic signed [AccW-1:0]        ra, rb, ro;
    logic [LogN:0]                 bin;
    logic                          keep;
    logic signed [AccW-1:0]        smax, smin;

    genvar g;
    generate
        for (g = 0; g < DFT_POINTS; g++)
        begin : g_tab
            assign cos_tab[g] = twiddle(g, DFT_POINTS, 1'b0);
            assign sin_tab[g] = twiddle(g, DFT_POINTS, 1'b1);
        end
    endgenerate

    assign tw_idx = LogN'(row * col);

    // Stage 1: fetch operands and twiddle.
    always_ff @(posedge clk)
    begin
        if (cmd.store_sample)
        begin
            samp_mem[load_idx] <= sample_in;
        end
        samp_rd_reg <= samp_mem[col];
        re_rd_reg   <= re_mem[col];
        im_rd_reg   <= im_mem[col];
        cos_reg     <= cos_tab[tw_idx];
        sin_reg     <= sin_tab[tw_idx];
        fwd_v_reg   <= cmd.fwd_mac;
        inv_v_reg   <= cmd.inv_mac;
        clr_reg     <= cmd.fwd_clear || cmd.inv_clear;
        live_reg    <= ({1'b0, col} < len);
    end

    // Stage 2: multiply.
    always_ff @(posedge clk)
    begin
        fwd_v2_reg <= fwd_v_reg;
        inv_v2_reg <= inv_v_reg;
        clr2_reg   <= clr_reg;
        if (fwd_v_reg)
        begin
            pa_reg <= live_reg ? ProdW'(samp_rd_reg) * ProdW'(cos_reg) : '0;
            pb_reg <= live_reg ? ProdW'(samp_rd_reg) * ProdW'(sin_reg) : '0;
        end
        else
        begin
            pa_reg <= ProdW'(re_rd_reg) * ProdW'(cos_reg);
            pb_reg <= ProdW'(im_rd_reg) * ProdW'(sin_reg);
        end
    end

    // Stage 3: accumulate.
    always_ff @(posedge clk)
    begin
        if (fwd_v2_reg || inv_v2_reg)
        begin
            acc_a_reg <= (clr2_reg ? '0 : acc_a_reg) + AccW'(pa_reg);
            acc_b_reg <= (clr2_reg ? '0 : acc_b_reg) + AccW'(pb_reg);
        end
    end

    assign bin  = (row <= LogN'(DFT_POINTS / 2 - 1)) || (row == LogN'(DFT_POINTS / 2))
                  ? {1'b0, row} : (LogN+1)'(DFT_POINTS) - {1'b0, row};
    assign keep = (32'(low_bin) <= 32'(bin)) && (32'(bin) <= 32'(high_bin));
    assign ra   = (acc_a_reg + (AccW'(1) <<< (FwdShift - 1))) >>> FwdShift;
    assign rb   = (-acc_b_reg + (AccW'(1) <<< (FwdShift - 1))) >>> FwdShift;
    assign ro   = ((acc_a_reg - acc_b_reg) + (AccW'(1) <<< (InvShift - 1))) >>> InvShift;
    assign smax = AccW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    assign smin = -smax - AccW'(1);

    // Write back the masked bin once the drain columns have settled the accumulator.
    always_ff @(posedge clk)
    begin
        if (cmd.fwd_write)
        begin
            re_mem[row] <= keep ? SpecW'(ra) : '0;
            im_mem[row] <= keep ? SpecW'(rb) : '0;
        end
    end

    always_comb
    begin
        if (ro > smax)
        begin
            filtered_out = smax[SAMPLE_WIDTH-1:0];
        end
        else if (ro < smin)
        begin
            filtered_out = smin[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            filtered_out = ro[SAMPLE_WIDTH-1:0];
        end
    end
endmodule
`default_nettype wire

/* rtl/ideal_dft_bandpass_series.sv */
// Top level: ideal DFT band-pass filter over one sample series.
`default_nettype none
// Samples of one series are taken one beat per cycle into a sample store.
// When series_length samples are in, the block stops accepting beats and
// runs a direct forward DFT with one shared multiply-accumulate unit (one
// twiddle product pair per cycle: N columns, then drain columns for the
// multiply pipeline and one write-back per bin, for all N bins), zeroes
// the bins outside low_bin..high_bin in both halves of the spectrum, then
// runs the inverse DFT the same way for each of the series_length output
// points (each held while the output is stalled) and sends each filtered
// sample as an output beat, marking the last one. The store is read at
// one address per cycle. Write configuration only while the block is
// waiting for samples with none pending. series_length is clamped to
// 1..min(64, DFT_POINTS).
module ideal_dft_bandpass_series
    import idbs_pkg::*;
#(
    parameter int DFT_POINTS   = DftPointsDefault,
    parameter int SAMPLE_WIDTH = SampleWidthDefault
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      filtered_out,
    output logic                                last_of_series,
    input  wire logic                           cfg_we,
    input  wire logic [CfgIdxWidth-1:0]         cfg_index,
    input  wire logic [CfgWidth-1:0]            cfg_data
);
    localparam int LogN  = $clog2(DFT_POINTS);
    localparam int Limit = (DFT_POINTS < ResultsMax) ? DFT_POINTS : ResultsMax;

    logic [6:0] series_length_reg;
    logic [5:0] low_bin_reg;
    logic [4:0] high_bin_reg;
    logic [LogN:0] len;
    logic          in_ready;
    idbs_cmd_t     cmd;
    logic [LogN-1:0] row, col;
    logic [LogN-1:0] load_idx_reg;

    // Hold configuration; write it only while idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_length_reg <= 7'd64;
            low_bin_reg       <= 6'd1;
            high_bin_reg      <= 5'd31;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SERIES_LENGTH: series_length_reg <= cfg_data;
                REG_LOW_BIN:       low_bin_reg       <= cfg_data[5:0];
                REG_HIGH_BIN:      high_bin_reg      <= cfg_data[4:0];
                default:           ;
            endcase
        end
    end

    // Clamp the length to 1 and to the smaller of the transform size and ResultsMax.
    always_comb
    begin
        if (series_length_reg == '0)
        begin
            len = (LogN+1)'(1);
        end
        else if (32'(series_length_reg) > Limit)
        begin
            len = (LogN+1)'(Limit);
        end
        else
        begin
            len = (LogN+1)'(series_length_reg);
        end
    end

    // Track the store write address alongside the controller's load count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg <= '0;
        end
        else if (cmd.store_sample)
        begin
            load_idx_reg <= load_idx_reg + 1'b1;
        end
        else if (cmd.inv_emit && last_of_series)
        begin
            load_idx_reg <= '0;
        end
    end

    assign in_stall = !in_ready;

    idbs_ctrl #(
        .DFT_POINTS (DFT_POINTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_busy  (out_stall),
        .len       (len),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .last      (last_of_series),
        .cmd       (cmd),
        .row       (row),
        .col       (col)
    );

    idbs_datapath #(
        .DFT_POINTS   (DFT_POINTS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .row          (row),
        .col          (col),
        .load_idx     (load_idx_reg),
        .len          (len),
        .low_bin      (low_bin_reg),
        .high_bin     (high_bin_reg),
        .sample_in    (sample_in),
        .filtered_out (filtered_out)
    );
endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for the DFT band-pass series block: directed table, random series, bit-exact predictor.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import idbs_pkg::*;

    localparam int Points   = 64;
    localparam int LogPts   = 6;
    localparam int SampW    = 16;
    localparam int RandBeats = 150;

    // One stimulus row: a register write, a sample beat, or a pause until idle.
    typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_IDLE} row_kind_e;
    typedef struct {
        row_kind_e             kind;
        logic [CfgIdxWidth-1:0] idx;
        int                    value;
        bit                    zero_out; // typed-in expectation: all outputs zero
    } row_t;

    typedef struct {
        logic signed [SampW-1:0] value;
        logic                    last;
    } filt_beat_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [SampW-1:0] sample_in;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [SampW-1:0] filtered_out;
    logic                    last_of_series;
    logic                    cfg_we;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [CfgWidth-1:0]     cfg_data;

    ideal_dft_bandpass_series i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_in      (sample_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_out   (filtered_out),
        .last_of_series (last_of_series),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Predictor state: twiddles, sample store / spectrum, load counter, registers.
    longint     cos_q16 [Points];
    longint     sin_q16 [Points];
    longint     store_re [Points];
    longint     spec_re [Points];
    longint     spec_im [Points];
    int         loaded;
    logic [6:0] len_reg;
    logic [5:0] lo_reg;
    logic [4:0] hi_reg;

    filt_beat_t filt_q [$];
    row_t       stim_tbl [$];
    int         errors;
    int         beats_in;
    int         beats_out;
    int         series_done;
    bit         valid_held;  // in_valid still high from the last accepted beat
    bit         tx_calm;
    bit         rx_calm;
    int         rx_hold;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Q30 quarter-wave cos/sin from the first nine Taylor terms.
    function automatic void quarter_cs(input longint ang, output longint c, output longint s);
        longint sq;
        longint term_c;
        longint term_s;
        sq = (ang * ang) >>> 30;
        term_c = 64'sd1 <<< 30;
        term_s = ang;
        c = term_c;
        s = term_s;
        for (int k = 1; k <= 8; k++)
        begin
            term_c = ((term_c * sq) >>> 30) / longint'((2 * k - 1) * (2 * k));
            term_s = ((term_s * sq) >>> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                c -= term_c;
                s -= term_s;
            end
            else
            begin
                c += term_c;
                s += term_s;
            end
        end
    endfunction

    function automatic void build_twiddle_table();
        longint c;
        longint s;
        int     quad;
        int     rem;
        for (int m = 0; m < Points; m++)
        begin
            quad = m / (Points / 4);
            rem  = m % (Points / 4);
            quarter_cs((64'sd6746518852 * longint'(rem)) / Points, c, s);
            c = (c + (64'sd1 <<< 13)) >>> 14;
            s = (s + (64'sd1 <<< 13)) >>> 14;
            case (quad)
                0: begin cos_q16[m] = c;  sin_q16[m] = s;  end
                1: begin cos_q16[m] = -s; sin_q16[m] = c;  end
                2: begin cos_q16[m] = -c; sin_q16[m] = -s; end
                default: begin cos_q16[m] = s; sin_q16[m] = -c; end
            endcase
        end
    endfunction

    function automatic longint round_half_up(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // Mirror a register write into the predictor.
    function automatic void apply_reg(input logic [CfgIdxWidth-1:0] idx, input int value);
        case (idx)
            REG_SERIES_LENGTH: len_reg = value[6:0];
            REG_LOW_BIN:       lo_reg  = value[5:0];
            REG_HIGH_BIN:      hi_reg  = value[4:0];
            default: ;
        endcase
    endfunction

    // Take one accepted sample; when the series closes, queue its filtered beats.
    function automatic void predict_filtered(input logic signed [SampW-1:0] x,
                                             input bit zero_out);
        int         len;
        int         bin;
        longint     acc_r;
        longint     acc_i;
        longint     y;
        filt_beat_t fb;
        len = int'(len_reg);
        if (len < 1) len = 1;
        if (len > Points) len = Points;
        if (loaded < len)
        begin
            store_re[loaded] = longint'(x);
            loaded++;
        end
        if (loaded < len) return;
        for (int n = len; n < Points; n++) store_re[n] = 0;
        for (int k = 0; k < Points; k++)
        begin
            bin = (k <= Points / 2) ? k : Points - k;
            acc_r = 0;
            acc_i = 0;
            if (bin >= int'(lo_reg) && bin <= int'(hi_reg))
                for (int n = 0; n < len; n++)
                begin
                    acc_r += store_re[n] * cos_q16[(k * n) % Points];
                    acc_i -= store_re[n] * sin_q16[(k * n) % Points];
                end
            spec_re[k] = round_half_up(acc_r, TwidFrac + LogPts - GuardBits);
            spec_im[k] = round_half_up(acc_i, TwidFrac + LogPts - GuardBits);
        end
        for (int n = 0; n < len; n++)
        begin
            acc_r = 0;
            for (int k = 0; k < Points; k++)
                acc_r += spec_re[k] * cos_q16[(k * n) % Points]
                       - spec_im[k] * sin_q16[(k * n) % Points];
            y = round_half_up(acc_r, TwidFrac + GuardBits);
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            fb.value = zero_out ? '0 : SampW'(y);
            fb.last  = (n == len - 1);
            filt_q.push_back(fb);
        end
        loaded = 0;
        series_done++;
    endfunction

    // Drop in_valid if it is still up from the last accepted beat.
    task automatic release_valid();
        if (valid_held)
        begin
            in_valid   <= 1'b0;
            valid_held = 1'b0;
        end
    endtask

    task automatic send_sample(input logic signed [SampW-1:0] x, input bit zero_out);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            release_valid();
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= x;
        do @(posedge clk); while (in_stall);
        // accepted at this edge; keep valid up so a back-to-back beat needs no toggle
        valid_held = 1'b1;
        beats_in++;
        predict_filtered(x, zero_out);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input int value);
        release_valid();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CfgWidth'(value);
        @(posedge clk);
        apply_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Hold until every expected beat is out, then let the block settle.
    task automatic wait_idle();
        release_valid();
        @(posedge clk);
        while (filt_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic void add_row(input row_kind_e kind, input logic [CfgIdxWidth-1:0] idx,
                                    input int value, input bit zero_out);
        row_t r;
        r.kind = kind;
        r.idx = idx;
        r.value = value;
        r.zero_out = zero_out;
        stim_tbl.push_back(r);
    endfunction

    function automatic logic signed [SampW-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SampW'($signed($urandom_range(0, 255)) - 128);
            default: return SampW'($urandom);
        endcase
    endfunction

    // Output side: check every beat against the oldest expectation, stall at random.
    initial
    begin
        out_stall = 1'b0;
        rx_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                beats_out++;
                if (filt_q.size() == 0)
                begin
                    $display("%0t unexpected beat: expected none, actual %0d last %0b",
                             $time, filtered_out, last_of_series);
                    errors++;
                end
                else
                begin
                    filt_beat_t fb;
                    fb = filt_q.pop_front();
                    if (filtered_out !== fb.value)
                    begin
                        $display("%0t filtered_out mismatch: expected %0d, actual %0d",
                                 $time, fb.value, filtered_out);
                        errors++;
                    end
                    if (last_of_series !== fb.last)
                    begin
                        $display("%0t last_of_series mismatch: expected %0b, actual %0b",
                                 $time, fb.last, last_of_series);
                        errors++;
                    end
                end
                rx_hold = rx_calm ? 0 : $urandom_range(0, 8);
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Switch the output side at random between stalling and streaming.
    initial
    begin
        rx_calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(100, 600)) @(posedge clk);
            rx_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog: far above the slowest legal run.
    initial
    begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int  n_beats;
        int  len;
        int  lim;
        row_t r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_in = '0;
        cfg_we = 1'b0;
        cfg_index = REG_SERIES_LENGTH;
        cfg_data = '0;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        series_done = 0;
        valid_held = 1'b0;
        tx_calm = 1'b0;
        loaded = 0;
        len_reg = 7'd64;
        lo_reg = 6'd1;
        hi_reg = 5'd31;
        build_twiddle_table();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-sample series at the sample extremes, band 0..31.
        add_row(ROW_CFG, REG_SERIES_LENGTH, 1, 0);
        add_row(ROW_CFG, REG_LOW_BIN, 0, 0);
        add_row(ROW_CFG, REG_HIGH_BIN, 31, 0);
        add_row(ROW_SAMPLE, REG_SERIES_LENGTH, 32767, 0);
        add_row(ROW_SAMPLE, REG_SERIES_LENGTH, -32768, 0);
        add_row(ROW_SAMPLE, REG_SERIES_LENGTH, -1, 0);
        // Empty band (low above high): every output reads zero.
        add_row(ROW_CFG, REG_SERIES_LENGTH, 2, 0);
        add_row(ROW_CFG, REG_LOW_BIN, 5, 0);
        add_row(ROW_CFG, REG_HIGH_BIN, 3, 0);
        add_row(ROW_SAMPLE, REG_SERIES_LENGTH, 32767, 1);
        add_row(ROW_SAMPLE, REG_SERIES_LENGTH, -32768, 1);
        // Zero length clamps to one; top low bin empties the band again.
        add_row(ROW_CFG, REG_SERIES_LENGTH, 0, 0);
        add_row(ROW_CFG, REG_LOW_BIN, 63, 0);
        add_row(ROW_SAMPLE, REG_SERIES_LENGTH, 12345, 1);
        // Length lowered mid-series: next sample is dropped and the series closes.
        add_row(ROW_CFG, REG_SERIES_LENGTH, 8, 0);
        add_row(ROW_CFG, REG_LOW_BIN, 1, 0);
        add_row(ROW_SAMPLE, REG_SERIES_LENGTH, 20000, 0);
        add_row(ROW_SAMPLE, REG_SERIES_LENGTH, -20000, 0);
        add_row(ROW_SAMPLE, REG_SERIES_LENGTH, 1, 0);
        add_row(ROW_SAMPLE, REG_SERIES_LENGTH, 0, 0);
        add_row(ROW_SAMPLE, REG_SERIES_LENGTH, 32767, 0);
        add_row(ROW_IDLE, REG_SERIES_LENGTH, 0, 0);
        add_row(ROW_CFG, REG_SERIES_LENGTH, 3, 0);
        add_row(ROW_SAMPLE, REG_SERIES_LENGTH, -5, 0);

        foreach (stim_tbl[i])
        begin
            r = stim_tbl[i];
            case (r.kind)
                ROW_CFG:    begin wait_idle(); write_reg(r.idx, r.value); end
                ROW_SAMPLE: send_sample(SampW'(r.value), r.zero_out);
                default:    wait_idle();
            endcase
        end

        // Random phases: a setting, then whole series (sometimes cut short).
        n_beats = 0;
        for (int ph = 0; n_beats < RandBeats; ph++)
        begin
            wait_idle();
            tx_calm = ($urandom_range(0, 3) == 0);
            if (ph == 0)
                len = 127;  // above range: clamps to a full 64-point series
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
            else if ($urandom_range(0, 3) == 0)
                len = $urandom_range(33, 64);
            else
                len = $urandom_range(2, 32);
            write_reg(REG_SERIES_LENGTH, len);
            case ($urandom_range(0, 5))
                0: begin write_reg(REG_LOW_BIN, 0); write_reg(REG_HIGH_BIN, 31); end
                1: begin write_reg(REG_LOW_BIN, $urandom_range(32, 63));
                         write_reg(REG_HIGH_BIN, $urandom_range(0, 31)); end
                default:
                begin
                    write_reg(REG_LOW_BIN, $urandom_range(0, 20));
                    write_reg(REG_HIGH_BIN, $urandom_range(0, 31));
                end
            endcase
            lim = (len < 1) ? 1 : ((len > Points) ? Points : len);
            if ($urandom_range(0, 5) == 0 && lim > 2)
            begin
                // broken series: stop partway, shorten, and let one beat close it
                repeat ($urandom_range(2, lim - 1))
                begin
                    send_sample(rand_sample(), 0);
                    n_beats++;
                end
                wait_idle();
                write_reg(REG_SERIES_LENGTH, $urandom_range(1, loaded));
                send_sample(rand_sample(), 0);
                n_beats++;
            end
            else
                repeat (lim * $urandom_range(1, 2))
                begin
                    send_sample(rand_sample(), 0);
                    n_beats++;
                end
        end

        wait_idle();
        repeat (200) @(posedge clk);
        $display("Run covered %0d sample beats in, %0d filtered beats out, %0d series.",
                 beats_in, beats_out, series_done);
        $display("Settings swept: lengths 0..127 (clamped), empty and full bands, drop case.");
        if (errors == 0 && filt_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
